// ----- rtl/rru_pkg.sv -----
// Package for the ray refraction unit: word types and fixed-point constants.
// No dependencies.
package rru_pkg;

   localparam int unsigned ETA_FRAC_BITS = 13;
   localparam int unsigned LANES = 3;

   typedef struct packed {
      logic signed [15:0] incident_x;
      logic signed [15:0] incident_y;
      logic signed [15:0] incident_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic [15:0]        index_ratio;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] refracted_x;
      logic signed [15:0] refracted_y;
      logic signed [15:0] refracted_z;
      logic               total_reflection;
      logic               saturated;
   } rsp_word_type;

endpackage

// ----- rtl/rru_isqrt.sv -----
// Pipelined integer square root, two result bits resolved per stage.
// Depends on nothing; carries a valid bit and a side payload through.
module rru_isqrt #(
   parameter int unsigned IN_W   = 30,
   parameter int unsigned SIDE_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [IN_W-1:0]      in_value,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [IN_W/2-1:0]    out_root,
   output logic [SIDE_W-1:0]    out_side
);
   localparam int unsigned RW = IN_W / 2;
   localparam int unsigned STEPS = RW;
   localparam int unsigned PER = 2;
   localparam int unsigned NST = (STEPS + PER - 1) / PER;

   logic [IN_W-1:0]   rem_ff  [NST+1];
   logic [IN_W-1:0]   rem_in  [NST+1];
   logic [RW-1:0]     root_ff [NST+1];
   logic [RW-1:0]     root_in [NST+1];
   logic [SIDE_W-1:0] side_ff [NST+1];
   logic              vld_ff  [NST+1];

   always_comb begin
      rem_in[0]  = in_value;
      root_in[0] = '0;
      for (int s = 0; s < NST; s++) begin
         logic [IN_W-1:0] r;
         logic [RW-1:0]   q;
         logic [IN_W+1:0] trial;
         r = rem_ff[s];
         q = root_ff[s];
         for (int k = 0; k < PER; k++) begin
            int b;
            b = STEPS - 1 - (s * PER + k);
            if (b >= 0) begin
               trial = ((IN_W+2)'(q) << (b + 1)) | ((IN_W+2)'(1) << (2 * b));
               if ((IN_W+2)'(r) >= trial) begin
                  r = IN_W'((IN_W+2)'(r) - trial);
                  q = q | (RW'(1) << b);
               end
            end
         end
         rem_in[s+1]  = r;
         root_in[s+1] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= rem_in[0];
         root_ff[0] <= root_in[0];
         side_ff[0] <= in_side;
         for (int s = 0; s < NST; s++) begin
            rem_ff[s+1]  <= rem_in[s+1];
            root_ff[s+1] <= root_in[s+1];
            side_ff[s+1] <= side_ff[s];
         end
      end
      if (reset) begin
         for (int s = 0; s <= NST; s++) vld_ff[s] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int s = 0; s < NST; s++) vld_ff[s+1] <= vld_ff[s];
      end
   end

   assign out_valid = vld_ff[NST];
   assign out_root  = root_ff[NST];
   assign out_side  = side_ff[NST];
endmodule

// ----- rtl/rru_lane.sv -----
// One vector lane: parallel part for one component, its square, and the final
// combine with the shared root. Depends on rru_pkg.
module rru_lane #(
   parameter int unsigned FB = 14
) (
   input  logic                 clock,
   input  logic                 advance,
   input  logic signed [15:0]   d_comp,
   input  logic signed [15:0]   n_comp,
   input  logic signed [FB+20:0] cos_val,
   input  logic [15:0]          eta,
   output logic signed [31:0]   p_out,
   output logic [63:0]          sq_out,
   input  logic signed [31:0]   p_late,
   input  logic signed [15:0]   n_late,
   input  logic [FB:0]          root,
   output logic signed [15:0]   r_out,
   output logic                 r_sat
);
   localparam int unsigned CW = FB + 21;
   localparam int unsigned TW = CW + 18;

   logic signed [CW+16:0] ncos_ff, ncos_in;
   logic signed [15:0]    d_ff;
   logic [15:0]           e1_ff, e2_ff;
   logic signed [TW-1:0]  t_ff, t_in;
   logic signed [TW+17:0] pe_ff, pe_in;
   logic signed [31:0]    p_ff, p_in;
   logic signed [31:0]    pd_ff;
   logic [63:0]           sq_ff, sq_in;
   logic signed [FB+19:0] ns_ff, ns_in;
   logic signed [31:0]    pl_ff;

   always_comb begin
      logic signed [CW+16:0] rr;
      logic signed [TW+17:0] pr;
      logic signed [TW+17:0] hi, lo;
      logic [31:0] a;
      ncos_in = (CW+17)'(n_comp) * (CW+17)'(cos_val);
      rr = (ncos_ff + ((CW+17)'(1) <<< (FB - 1))) >>> FB;
      t_in = TW'(d_ff) + TW'(rr);
      pe_in = (TW+18)'(t_ff) * (TW+18)'($signed({1'b0, e2_ff}));
      pr = (pe_ff + ((TW+18)'(1) <<< (rru_pkg::ETA_FRAC_BITS - 1))) >>> rru_pkg::ETA_FRAC_BITS;
      hi = (TW+18)'(32'sh7fffffff);
      lo = -(TW+18)'(64'sh80000000);
      if (pr > hi) p_in = 32'sh7fffffff;
      else if (pr < lo) p_in = 32'sh80000000;
      else p_in = 32'(pr);
      a = p_ff[31] ? 32'(-p_ff) : 32'(p_ff);
      sq_in = 64'(a) * 64'(a);
      ns_in = (FB+20)'(n_late) * (FB+20)'($signed({1'b0, root}));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ncos_ff <= ncos_in;
         d_ff    <= d_comp;
         e1_ff   <= eta;
         t_ff    <= t_in;
         e2_ff   <= e1_ff;
         pe_ff   <= pe_in;
         p_ff    <= p_in;
         pd_ff   <= p_ff;
         sq_ff   <= sq_in;
         ns_ff   <= ns_in;
         pl_ff   <= p_late;
      end
   end

   assign p_out  = pd_ff;
   assign sq_out = sq_ff;

   always_comb begin
      logic signed [FB+19:0] nr;
      logic signed [FB+21:0] r;
      nr = (ns_ff + ((FB+20)'(1) <<< (FB - 1))) >>> FB;
      r = (FB+22)'(pl_ff) - (FB+22)'(nr);
      r_sat = 1'b0;
      if (r > (FB+22)'(32767)) begin
         r_out = 16'sh7fff; r_sat = 1'b1;
      end else if (r < -(FB+22)'(32768)) begin
         r_out = 16'sh8000; r_sat = 1'b1;
      end else begin
         r_out = 16'(r);
      end
   end
endmodule

// ----- rtl/ray_refraction_unit.sv -----
// Top level of the ray refraction unit: dot product, three lanes, shared root,
// merge and output register. Depends on rru_pkg, rru_lane, rru_isqrt.
//
//  channel | direction | word type
//  req     | in        | rru_pkg::req_word_type
//  rsp     | out       | rru_pkg::rsp_word_type
//
// One word per cycle while rsp is not stalled.
// Synchronous active-high reset clears all valid bits.
// The pipe advances whenever its last stage is empty or the output register drains;
// req_ready follows that, so a stalled rsp stalls the whole pipe.
module ray_refraction_unit #(
   parameter int unsigned FRACTION_BITS = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rru_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rru_pkg::rsp_word_type rsp_data
);
   localparam int unsigned FB = FRACTION_BITS;
   localparam int unsigned CW = FB + 21;
   localparam int unsigned RADW = 2 * FB + 2;
   localparam int unsigned SIDE = 1 + 3 * 32 + 3 * 16;
   localparam int unsigned DL = 9;
   localparam int unsigned WD = 8;

   logic advance;
   logic vld_ff [DL];
   rru_pkg::req_word_type w_ff [WD];
   logic signed [33:0] prod_ff [3];
   logic signed [35:0] dot_ff;
   logic signed [CW-1:0] cos_ff;
   logic signed [31:0] p_w [3];
   logic [63:0] sq_w [3];
   logic [65:0] sum_ff;
   logic signed [31:0] pq_ff [3];
   rru_pkg::req_word_type nq_ff;
   logic tir_w;
   logic [RADW-1:0] rad_w;
   logic sq_v;
   logic [RADW/2-1:0] root_w;
   logic [SIDE-1:0] side_in, side_out;
   logic signed [15:0] r_w [3];
   logic s_w [3];
   logic rv_ff, tir_ff;
   rru_pkg::rsp_word_type rsp_ff;
   logic rsp_vld_ff;

   assign advance   = !rsp_vld_ff || rsp_ready;
   assign req_ready = advance;

   logic signed [15:0] dc [3][2];
   always_comb begin
      dc[0][0] = req_data.incident_x; dc[0][1] = req_data.normal_x;
      dc[1][0] = req_data.incident_y; dc[1][1] = req_data.normal_y;
      dc[2][0] = req_data.incident_z; dc[2][1] = req_data.normal_z;
   end

   logic signed [35:0] dot_in;
   logic signed [CW-1:0] cos_in;
   always_comb begin
      dot_in = 36'(prod_ff[0]) + 36'(prod_ff[1]) + 36'(prod_ff[2]);
      cos_in = CW'((-(37'(dot_ff)) + (37'(1) <<< (FB - 1))) >>> FB);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         w_ff[0] <= req_data;
         for (int i = 0; i < 3; i++) prod_ff[i] <= 34'(dc[i][0]) * 34'(dc[i][1]);
         w_ff[1] <= w_ff[0];
         dot_ff  <= dot_in;
         w_ff[2] <= w_ff[1];
         cos_ff  <= cos_in;
         for (int i = 3; i < WD; i++) w_ff[i] <= w_ff[i-1];
         sum_ff  <= 66'(sq_w[0]) + 66'(sq_w[1]) + 66'(sq_w[2]);
         for (int i = 0; i < 3; i++) pq_ff[i] <= p_w[i];
         nq_ff   <= w_ff[WD-1];
      end
      if (reset) begin
         for (int i = 0; i < DL; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < DL; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   logic signed [15:0] dl [3];
   logic signed [15:0] nl [3];
   always_comb begin
      dl[0] = w_ff[2].incident_x; dl[1] = w_ff[2].incident_y; dl[2] = w_ff[2].incident_z;
      nl[0] = w_ff[2].normal_x;   nl[1] = w_ff[2].normal_y;   nl[2] = w_ff[2].normal_z;
   end

   logic [31:0] pl [3];
   logic signed [15:0] nlat [3];
   always_comb begin
      for (int i = 0; i < 3; i++) pl[i] = side_out[1 + 32*i +: 32];
      for (int i = 0; i < 3; i++) nlat[i] = side_out[97 + 16*i +: 16];
   end

   for (genvar g = 0; g < rru_pkg::LANES; g++) begin : g_lane
      rru_lane #(.FB(FB)) u_lane (
         .clock(clock), .advance(advance),
         .d_comp(dl[g]), .n_comp(nl[g]),
         .cos_val(cos_ff), .eta(w_ff[2].index_ratio),
         .p_out(p_w[g]), .sq_out(sq_w[g]),
         .p_late($signed(pl[g])), .n_late(nlat[g]), .root(root_w),
         .r_out(r_w[g]), .r_sat(s_w[g])
      );
   end

   // lane p and sq arrive five stages after w_ff[2]; sum_ff, pq_ff and nq_ff line up
   always_comb begin
      logic [65:0] one;
      one = 66'(1) << (2 * FB);
      tir_w = sum_ff > one;
      rad_w = tir_w ? '0 : RADW'(one - sum_ff);
      side_in = {nq_ff.normal_z, nq_ff.normal_y, nq_ff.normal_x,
                 pq_ff[2], pq_ff[1], pq_ff[0], tir_w};
   end

   rru_isqrt #(.IN_W(RADW), .SIDE_W(SIDE)) u_sqrt (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(vld_ff[DL-1]), .in_value(rad_w), .in_side(side_in),
      .out_valid(sq_v), .out_root(root_w), .out_side(side_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (advance) begin
         rv_ff <= sq_v;
      end
      if (advance) tir_ff <= side_out[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= rv_ff;
      end
      if (advance) begin
         if (tir_ff) begin
            rsp_ff <= '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0};
         end else begin
            rsp_ff <= '{r_w[0], r_w[1], r_w[2], 1'b0, s_w[0] | s_w[1] | s_w[2]};
         end
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_zero_on_tir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.total_reflection |->
         rsp_data.refracted_x == 0 && rsp_data.refracted_y == 0 &&
         rsp_data.refracted_z == 0 && !rsp_data.saturated)
      else $error("total reflection word carries nonzero data");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(rv_ff) && $stable(vld_ff[0]))
      else $error("pipe moved while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("ready not tied to output drain");
`endif
endmodule
